/* rtl/occ_pkg.sv */
// Shared constants, payload types and chain types for the orthogonal crossing counter.
package occ_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int COORD_W     = 32;
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int COUNT_W     = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_W-1:0] end_a_x;
        logic signed [COORD_W-1:0] end_a_y;
        logic signed [COORD_W-1:0] end_b_x;
        logic signed [COORD_W-1:0] end_b_y;
        logic                      is_last;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] crossing_count;
        logic               overflow;
    } out_item_t;

    // fixed coordinate plus normalised span
    typedef struct packed {
        logic signed [COORD_W-1:0] fixed_c;
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
    } seg_entry_t;

    // segment travelling along the chain
    typedef struct packed {
        logic               valid;
        logic               is_h;
        logic               is_v;
        logic               last;
        seg_entry_t         seg;
        logic [FILL_W-1:0]  count;
    } token_t;

endpackage

/* rtl/occ_cell.sv */
// One chain cell: a horizontal and a vertical slot, compared against the passing token.
module occ_cell
    import occ_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       h_we,
    input  logic       v_we,
    input  seg_entry_t wr_entry,
    input  logic       h_live,
    input  logic       v_live,
    input  token_t     tok_in,
    output token_t     tok_out
);

    seg_entry_t h_entry_reg;
    seg_entry_t v_entry_reg;
    token_t     tok_reg;
    token_t     tok_next;
    logic       hit_h;
    logic       hit_v;

    // token horizontal against stored vertical
    assign hit_h = tok_in.is_h && v_live
                   && (tok_in.seg.lo < v_entry_reg.fixed_c)
                   && (v_entry_reg.fixed_c < tok_in.seg.hi)
                   && (v_entry_reg.lo < tok_in.seg.fixed_c)
                   && (tok_in.seg.fixed_c < v_entry_reg.hi);

    // token vertical against stored horizontal
    assign hit_v = tok_in.is_v && h_live
                   && (h_entry_reg.lo < tok_in.seg.fixed_c)
                   && (tok_in.seg.fixed_c < h_entry_reg.hi)
                   && (tok_in.seg.lo < h_entry_reg.fixed_c)
                   && (h_entry_reg.fixed_c < tok_in.seg.hi);

    always_comb
    begin
        tok_next = tok_in;
        if (hit_h || hit_v)
        begin
            tok_next.count = tok_in.count + FILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            h_entry_reg <= wr_entry;
        end
        if (v_we)
        begin
            v_entry_reg <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* rtl/orthogonal_crossing_counter.sv */
// Top level: segment intake, fill control, cell chain and result register.
//
//  channel | signals                      | transaction
//  in      | in_valid, in_ready, in_item   | one segment with last marker
//  out     | out_valid, out_ready, out_item | crossing count and overflow flag
//
// One segment at a time: accepted, written into its slot if its store has room,
// then walked along the STORE_DEPTH cells, one cell per cycle, gathering its
// crossings with stored segments of the other orientation. Intake reopens
// when it leaves the chain, or, for a last item, when its result is registered.
// Reset empties both stores by clearing the fill counts; slots hold no reset.
// A waiting result does not block intake; a last item waits only for the slot.
module orthogonal_crossing_counter
    import occ_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic               busy_reg;
    logic               fin_reg;
    logic               inj_valid_reg;
    logic               inj_h_reg;
    logic               inj_v_reg;
    logic               inj_last_reg;
    seg_entry_t         inj_seg_reg;
    logic [FILL_W-1:0]  h_fill_reg;
    logic [FILL_W-1:0]  v_fill_reg;
    logic               dropped_reg;
    logic [COUNT_W-1:0] total_reg;
    logic               out_valid_reg;
    out_item_t          out_item_reg;

    logic               accept;
    logic               cls_h;
    logic               cls_v;
    seg_entry_t         cls_seg;
    logic               h_room;
    logic               v_room;
    logic               write_h;
    logic               write_v;
    logic [STORE_DEPTH-1:0] h_we;
    logic [STORE_DEPTH-1:0] v_we;
    logic [STORE_DEPTH-1:0] h_live;
    logic [STORE_DEPTH-1:0] v_live;
    token_t             tok_head;
    token_t             chain [STORE_DEPTH+1];
    token_t             tail;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] total_next;
    logic               finish;

    assign accept   = in_valid && in_ready;
    assign in_ready = !busy_reg;

    // classify and normalise
    always_comb
    begin
        cls_h = (in_item.end_a_y == in_item.end_b_y) && (in_item.end_a_x != in_item.end_b_x);
        cls_v = (in_item.end_a_x == in_item.end_b_x) && (in_item.end_a_y != in_item.end_b_y);
        if (cls_h)
        begin
            cls_seg.fixed_c = in_item.end_a_y;
            cls_seg.lo = (in_item.end_a_x < in_item.end_b_x) ? in_item.end_a_x : in_item.end_b_x;
            cls_seg.hi = (in_item.end_a_x < in_item.end_b_x) ? in_item.end_b_x : in_item.end_a_x;
        end
        else
        begin
            cls_seg.fixed_c = in_item.end_a_x;
            cls_seg.lo = (in_item.end_a_y < in_item.end_b_y) ? in_item.end_a_y : in_item.end_b_y;
            cls_seg.hi = (in_item.end_a_y < in_item.end_b_y) ? in_item.end_b_y : in_item.end_a_y;
        end
    end

    assign h_room  = (h_fill_reg != FILL_W'(STORE_DEPTH));
    assign v_room  = (v_fill_reg != FILL_W'(STORE_DEPTH));
    assign write_h = inj_valid_reg && inj_h_reg && h_room;
    assign write_v = inj_valid_reg && inj_v_reg && v_room;

    always_comb
    begin
        tok_head.valid = inj_valid_reg;
        tok_head.is_h  = write_h;
        tok_head.is_v  = write_v;
        tok_head.last  = inj_last_reg;
        tok_head.seg   = inj_seg_reg;
        tok_head.count = '0;
    end

    assign chain[0] = tok_head;

    for (genvar i = 0; i < STORE_DEPTH; i++)
    begin : g_cell
        assign h_we[i]   = write_h && (h_fill_reg == FILL_W'(i));
        assign v_we[i]   = write_v && (v_fill_reg == FILL_W'(i));
        assign h_live[i] = (FILL_W'(i) < h_fill_reg);
        assign v_live[i] = (FILL_W'(i) < v_fill_reg);

        occ_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .h_we     (h_we[i]),
            .v_we     (v_we[i]),
            .wr_entry (inj_seg_reg),
            .h_live   (h_live[i]),
            .v_live   (v_live[i]),
            .tok_in   (chain[i]),
            .tok_out  (chain[i+1])
        );
    end

    assign tail = chain[STORE_DEPTH];

    // saturating accumulate
    always_comb
    begin
        sum = {1'b0, total_reg} + (COUNT_W+1)'(tail.count);
        if (sum > (COUNT_W+1)'(COUNT_MAX))
        begin
            total_next = COUNT_MAX;
        end
        else
        begin
            total_next = sum[COUNT_W-1:0];
        end
    end

    assign finish = fin_reg && (!out_valid_reg || out_ready);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inj_seg_reg  <= cls_seg;
            inj_h_reg    <= cls_h;
            inj_v_reg    <= cls_v;
            inj_last_reg <= in_item.is_last;
        end
        if (finish)
        begin
            out_item_reg.crossing_count <= total_reg;
            out_item_reg.overflow       <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            inj_valid_reg <= 1'b0;
            h_fill_reg    <= '0;
            v_fill_reg    <= '0;
            dropped_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            inj_valid_reg <= accept;

            if (accept)
            begin
                busy_reg <= 1'b1;
            end

            if (write_h)
            begin
                h_fill_reg <= h_fill_reg + FILL_W'(1);
            end
            if (write_v)
            begin
                v_fill_reg <= v_fill_reg + FILL_W'(1);
            end
            if (inj_valid_reg && ((inj_h_reg && !h_room) || (inj_v_reg && !v_room)))
            begin
                dropped_reg <= 1'b1;
            end

            if (tail.valid)
            begin
                total_reg <= total_next;
                if (tail.last)
                begin
                    fin_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b0;
                end
            end

            if (finish)
            begin
                out_valid_reg <= 1'b1;
                fin_reg       <= 1'b0;
                busy_reg      <= 1'b0;
                total_reg     <= '0;
                h_fill_reg    <= '0;
                v_fill_reg    <= '0;
                dropped_reg   <= 1'b0;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for orthogonal_crossing_counter: segment sets in, crossing counts out.
module tb_top;
    import occ_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    logic calm = 1'b0;
    logic hold_rx = 1'b0;

    in_item_t  segment_backlog[$];
    out_item_t awaited_tallies[$];

    seg_entry_t        h_segs [STORE_DEPTH];
    seg_entry_t        v_segs [STORE_DEPTH];
    int                h_fill = 0;
    int                v_fill = 0;
    bit                dropped = 1'b0;

    int errors = 0;
    int segs_accepted = 0;
    int sets_checked = 0;
    int overflow_sets = 0;
    int peak_count = 0;

    orthogonal_crossing_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- predictor

    task automatic file_segment(input bit horiz, input int fixed, input int p, input int q);
        seg_entry_t e;
        e.fixed_c = fixed;
        e.lo      = (p < q) ? p : q;
        e.hi      = (p < q) ? q : p;
        if (horiz)
        begin
            if (h_fill >= STORE_DEPTH)
                dropped = 1'b1;
            else
            begin
                h_segs[h_fill] = e;
                h_fill++;
            end
        end
        else
        begin
            if (v_fill >= STORE_DEPTH)
                dropped = 1'b1;
            else
            begin
                v_segs[v_fill] = e;
                v_fill++;
            end
        end
    endtask

    function automatic logic [COUNT_W-1:0] tally_crossings();
        logic [COUNT_W-1:0] n;
        int hy, hl, hh, vx, vl, vh;
        n = '0;
        for (int i = 0; i < h_fill; i++)
        begin
            hy = h_segs[i].fixed_c;
            hl = h_segs[i].lo;
            hh = h_segs[i].hi;
            for (int j = 0; j < v_fill; j++)
            begin
                vx = v_segs[j].fixed_c;
                vl = v_segs[j].lo;
                vh = v_segs[j].hi;
                if (hl < vx && vx < hh && vl < hy && hy < vh && n != COUNT_MAX)
                    n++;
            end
        end
        return n;
    endfunction

    task automatic absorb_segment(input in_item_t it);
        int ax, ay, bx, by;
        out_item_t r;
        ax = it.end_a_x;
        ay = it.end_a_y;
        bx = it.end_b_x;
        by = it.end_b_y;
        if (ay == by && ax != bx)
            file_segment(1'b1, ay, ax, bx);
        else if (ax == bx && ay != by)
            file_segment(1'b0, ax, ay, by);
        if (it.is_last)
        begin
            r.crossing_count = tally_crossings();
            r.overflow       = dropped;
            awaited_tallies.insert(awaited_tallies.size(), r);
            h_fill  = 0;
            v_fill  = 0;
            dropped = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                absorb_segment(in_item);
                segs_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (segment_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 24))
                begin
                    in_valid <= 1'b1;
                    in_item  <= segment_backlog.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver and monitor

    always @(posedge clk)
    begin
        if (!rst_n || hold_rx)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 24);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_tallies.size() == 0)
            begin
                $error("unexpected result transaction: count %0d overflow %0d",
                       out_item.crossing_count, out_item.overflow);
                errors++;
            end
            else
            begin
                out_item_t want;
                want = awaited_tallies.pop_front();
                if (out_item.crossing_count !== want.crossing_count)
                begin
                    $error("crossing_count: expected %0d, actual %0d",
                           want.crossing_count, out_item.crossing_count);
                    errors++;
                end
                if (out_item.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0d, actual %0d", want.overflow, out_item.overflow);
                    errors++;
                end
                sets_checked++;
                if (want.overflow)
                    overflow_sets++;
                if (int'(want.crossing_count) > peak_count)
                    peak_count = int'(want.crossing_count);
            end
        end
    end

    // long receiver hold-off so a last segment backs up the input
    initial
    begin
        @(posedge rst_n);
        repeat (30000) @(posedge clk);
        hold_rx <= 1'b1;
        repeat (8000) @(posedge clk);
        hold_rx <= 1'b0;
    end

    // stretch with no idling on either side
    initial
    begin
        @(posedge rst_n);
        repeat (50000) @(posedge clk);
        calm <= 1'b1;
        repeat (60000) @(posedge clk);
        calm <= 1'b0;
    end

    initial
    begin
        #30000000;
        $display("simulation failed");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus

    task automatic add_item(input int ax, input int ay, input int bx, input int by,
                            input bit last);
        in_item_t it;
        it.end_a_x = ax;
        it.end_a_y = ay;
        it.end_b_x = bx;
        it.end_b_y = by;
        it.is_last = last;
        segment_backlog.insert(segment_backlog.size(), it);
    endtask

    function automatic int jitter(input int c, input int r);
        return c + int'($urandom_range(0, 2 * r)) - r;
    endfunction

    // orient: 0 mixed, 1 horizontal, 2 vertical
    task automatic add_random(input int ox, input int oy, input int r, input int orient,
                              input bit last, inout int kept);
        int roll, fx, fy;
        roll = (orient == 1) ? 0 : (orient == 2) ? 50 : $urandom_range(0, 99);
        if (roll < 42)
        begin
            fy = jitter(oy, r);
            add_item(jitter(ox, r), fy, jitter(ox, r), fy, last);
            kept++;
        end
        else if (roll < 84)
        begin
            fx = jitter(ox, r);
            add_item(fx, jitter(oy, r), fx, jitter(oy, r), last);
            kept++;
        end
        else if (roll < 90)
        begin
            fx = jitter(ox, r);
            fy = jitter(oy, r);
            add_item(fx, fy, fx, fy, last);
        end
        else if (roll < 96)
        begin
            fx = jitter(ox, r);
            fy = jitter(oy, r);
            add_item(fx, fy, fx + 1 + int'($urandom_range(0, r)),
                     fy - 1 - int'($urandom_range(0, r)), last);
        end
        else
            add_item(int'($urandom), int'($urandom), int'($urandom), int'($urandom), last);
    endtask

    initial
    begin
        int kept, n, r, ox, oy, h_left, v_left;
        int lo_c, hi_c;
        bit pick_h;

        lo_c = int'(32'h8000_0000);
        hi_c = int'(32'h7fff_ffff);

        // plain crossing, then reversed endpoint order
        add_item(-10, 0, 10, 0, 1'b0);
        add_item(0, -10, 0, 10, 1'b1);
        add_item(10, 5, -10, 5, 1'b0);
        add_item(3, 10, 3, -10, 1'b1);
        // L-bend and T-junctions touching only at endpoints
        add_item(0, 0, 10, 0, 1'b0);
        add_item(0, 0, 0, 10, 1'b0);
        add_item(10, -5, 10, 5, 1'b0);
        add_item(5, 0, 5, 10, 1'b0);
        add_item(5, -7, 5, 0, 1'b1);
        // zero-length and diagonal segments ignored, last on an ignored one
        add_item(-4, 2, 4, 2, 1'b0);
        add_item(7, 7, 7, 7, 1'b0);
        add_item(1, 1, 3, 3, 1'b0);
        add_item(0, -4, 0, 4, 1'b0);
        add_item(9, 9, 9, 9, 1'b1);
        // coordinate extremes
        add_item(lo_c, 0, hi_c, 0, 1'b0);
        add_item(0, hi_c, 0, lo_c, 1'b0);
        add_item(lo_c, hi_c, hi_c, hi_c, 1'b0);
        add_item(lo_c, lo_c, lo_c, hi_c, 1'b0);
        add_item(-1, -1, 1, -1, 1'b0);
        add_item(lo_c, lo_c, hi_c, hi_c, 1'b1);
        // lone sets
        add_item(3, 1, 3, 9, 1'b1);
        add_item(2, 5, -6, 1, 1'b1);

        // many small sets with random content
        kept = 0;
        while (kept < 650)
        begin
            n  = $urandom_range(1, 16);
            r  = ($urandom_range(0, 2) == 0) ? 3 : ($urandom_range(0, 1) ? 50 : 4000);
            ox = $urandom_range(0, 3) == 0 ? int'($urandom) : jitter(0, 100);
            oy = $urandom_range(0, 3) == 0 ? int'($urandom) : jitter(0, 100);
            for (int i = 0; i < n; i++)
                add_random(ox, oy, r, 0, i == n - 1, kept);
        end

        // one set that overruns both stores
        h_left = STORE_DEPTH + 6;
        v_left = STORE_DEPTH + 6;
        ox = jitter(0, 1000);
        oy = jitter(0, 1000);
        while (h_left + v_left > 0)
        begin
            pick_h = (v_left == 0) || (h_left != 0 && $urandom_range(0, 1) == 1);
            if (pick_h)
                h_left--;
            else
                v_left--;
            add_random(ox, oy, 200, pick_h ? 1 : 2, h_left + v_left == 0, kept);
        end

        @(posedge rst_n);
        while (segment_backlog.size() != 0 || in_valid)
            @(posedge clk);
        while (awaited_tallies.size() != 0)
            @(posedge clk);
        repeat (STORE_DEPTH + 16) @(posedge clk);

        if (awaited_tallies.size() != 0)
        begin
            $error("%0d expected results never arrived", awaited_tallies.size());
            errors++;
        end
        $display("%0d segments sent, %0d segment sets checked, %0d with a dropped segment",
                 segs_accepted, sets_checked, overflow_sets);
        $display("largest crossing count seen: %0d", peak_count);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/occ_pkg.sv
rtl/occ_cell.sv
rtl/orthogonal_crossing_counter.sv
tb/tb_top.sv
